// ----- hdl/rpu_pkg.sv -----
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared types, constants and small arithmetic helpers of the radial particle
// update block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpu_pkg;

  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 104;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  typedef enum logic [1:0] {
    CFG_EMITTER_X   = 2'd0,
    CFG_EMITTER_Y   = 2'd1,
    CFG_MOTION_MODE = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CMD_SPAWN   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  slot;
    logic [15:0] dt;
    logic [23:0] life;
    logic [15:0] start_angle;
    logic [15:0] angle_rate;
    logic [15:0] start_radius;
    logic [15:0] radius_rate;
    logic [31:0] start_color;
    logic [63:0] color_rate;
    logic [31:0] size_pack;
    logic [31:0] rotation_pack;
  } item_t;

  typedef struct packed {
    logic        live;
    logic [23:0] life;
    logic [15:0] angle;
    logic [15:0] arate;
    logic [15:0] radius;
    logic [15:0] rstep;
    logic [31:0] start_point;
    logic [63:0] color;
    logic [63:0] cstep;
    logic [31:0] size_st;
    logic [31:0] rot_st;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        alive;
    logic [5:0]  slot;
    logic [15:0] angle;
    logic [15:0] radius;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic [63:0] color;
    logic [15:0] size;
    logic [15:0] rotation;
  } emit_t;

  function automatic logic [15:0] color_in(input logic [7:0] c);
    logic [21:0] n;
    logic [44:0] p;
    n = {c, 14'd0} + 22'd127;
    p = 45'(n) * 45'd4210753;
    return {1'b0, p[44:30]};
  endfunction

  function automatic logic [7:0] color_out(input logic [15:0] v);
    logic [23:0] t;
    t = {v, 8'd0} - {8'd0, v} + 24'd8192;
    return t[21:14];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'h7fff;
    end else if (v < -19'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rpu_trig.sv -----
// ----------------------------------------------------------------------------
// rpu_trig
// Four-stage pipeline that returns sine and cosine in Q14 of a 16-bit phase
// through the quarter-wave polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module rpu_trig (
  input  wire logic               clk,
  input  wire logic [15:0]        phase,
  output      logic signed [15:0] sin_q14,
  output      logic signed [15:0] cos_q14
);
  import rpu_pkg::*;

  logic [14:0] x1 [2];
  logic [14:0] xs1 [2];
  logic        n1 [2];
  logic [14:0] x2 [2];
  logic [14:0] xs2 [2];
  logic [13:0] in2 [2];
  logic        n2 [2];
  logic [14:0] x3 [2];
  logic [14:0] out3 [2];
  logic        n3 [2];
  logic signed [15:0] res [2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      logic [1:0]  quad;
      logic [14:0] xv;
      logic [29:0] sq;
      logic [25:0] a;
      logic [28:0] b;
      logic [29:0] c;
      logic [14:0] r;
      quad = phase[15:14] + 2'(k);
      xv   = quad[0] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
      sq   = 30'(xv) * 30'(xv);
      x1[k]  <= xv;
      xs1[k] <= sq[28:14];
      n1[k]  <= quad[1];
      a = 26'(xs1[k]) * 26'd1306;
      x2[k]  <= x1[k];
      xs2[k] <= xs1[k];
      in2[k] <= 14'd10583 - a[25:14];
      n2[k]  <= n1[k];
      b = 29'(in2[k]) * 29'(xs2[k]);
      x3[k]   <= x2[k];
      out3[k] <= 15'd25736 - b[28:14];
      n3[k]   <= n2[k];
      c = 30'(x3[k]) * 30'(out3[k]);
      r = (c[29:14] > 16'd16384) ? 15'd16384 : c[28:14];
      res[k] <= n3[k] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    end
  end

  assign sin_q14 = res[0];
  assign cos_q14 = res[1];

endmodule

`default_nettype wire

// ----- hdl/rpu_slot_mem.sv -----
// ----------------------------------------------------------------------------
// rpu_slot_mem
// Slot memory with a registered read, the spawn and advance update and the
// write-back with forwarding; clears all slots after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rpu_slot_mem #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire rpu_pkg::item_t item,
  input  wire logic [15:0]    emitter_x,
  input  wire logic [15:0]    emitter_y,
  input  wire logic           motion_mode,
  output      logic           clearing,
  output      rpu_pkg::emit_t emit
);
  import rpu_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  entry_t          mem [SLOT_COUNT];
  entry_t          rd;
  entry_t          fwd_data;
  logic            fwd;
  logic [AW-1:0]   clr_cnt;
  logic            v1;
  logic            rng1;
  logic [AW-1:0]   addr1;
  item_t           item1;
  logic            in_range;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  entry_t          e;
  entry_t          upd;
  logic            alive;
  logic signed [16:0] dts;

  assign in_range = 32'(item.slot) < SLOT_COUNT;
  assign rd_addr  = in_range ? AW'(item.slot) : '0;
  assign wr_en    = clearing | (v1 & rng1);
  assign wr_addr  = clearing ? clr_cnt : addr1;
  assign wr_data  = clearing ? entry_t'('0) : upd;
  assign e        = fwd ? fwd_data : rd;
  assign dts      = $signed({1'b0, item1.dt});

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd       <= mem[rd_addr];
    fwd      <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
    if (accept) begin
      item1 <= item;
      addr1 <= rd_addr;
      rng1  <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      v1       <= 1'b0;
    end else begin
      v1 <= accept;
      if (clearing) begin
        if (clr_cnt == AW'(SLOT_COUNT - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic signed [32:0] p;
    logic signed [17:0] s;
    logic [15:0]        cv;
    p     = '0;
    s     = '0;
    cv    = '0;
    upd   = e;
    alive = 1'b0;
    if (item1.cmd == CMD_SPAWN) begin
      if (item1.life == '0) begin
        upd.live = 1'b0;
      end else begin
        upd.live        = 1'b1;
        upd.life        = item1.life;
        upd.angle       = item1.start_angle;
        upd.arate       = item1.angle_rate;
        upd.radius      = item1.start_radius;
        upd.rstep       = item1.radius_rate;
        upd.start_point = {emitter_x, emitter_y};
        for (int ch = 0; ch < 4; ch++) begin
          upd.color[16*ch +: 16] = color_in(item1.start_color[8*ch +: 8]);
        end
        upd.cstep   = item1.color_rate;
        upd.size_st = item1.size_pack;
        upd.rot_st  = item1.rotation_pack;
        alive = 1'b1;
      end
    end else if (e.live) begin
      if (e.life <= {8'd0, item1.dt}) begin
        upd.live = 1'b0;
      end else begin
        alive    = 1'b1;
        upd.life = e.life - {8'd0, item1.dt};
        p = $signed(e.arate) * dts;
        upd.angle = e.angle + p[23:8];
        p = $signed(e.rstep) * dts;
        s = $signed({{2{e.radius[15]}}, e.radius}) + $signed({p[32], p[32:16]});
        upd.radius = sat16(19'(s));
        for (int ch = 0; ch < 4; ch++) begin
          p  = $signed(e.cstep[16*ch +: 16]) * dts;
          cv = e.color[16*ch +: 16];
          s  = $signed({2'b00, cv}) + $signed({p[32], p[32:16]});
          if (s < 18'sd0) begin
            upd.color[16*ch +: 16] = '0;
          end else if (s > 18'sd16384) begin
            upd.color[16*ch +: 16] = 16'd16384;
          end else begin
            upd.color[16*ch +: 16] = s[15:0];
          end
        end
        p = $signed(e.size_st[15:0]) * dts;
        s = $signed({2'b00, e.size_st[31:16]}) + $signed({p[32], p[32:16]});
        if (s < 18'sd0) begin
          upd.size_st[31:16] = '0;
        end else if (s > 18'sd65535) begin
          upd.size_st[31:16] = 16'hffff;
        end else begin
          upd.size_st[31:16] = s[15:0];
        end
        p = $signed(e.rot_st[15:0]) * dts;
        upd.rot_st[31:16] = e.rot_st[31:16] + p[23:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit.valid <= 1'b0;
    end else begin
      emit.valid <= v1;
    end
    emit.alive    <= alive & rng1;
    emit.slot     <= item1.slot;
    emit.angle    <= upd.angle;
    emit.radius   <= upd.radius;
    emit.base_x   <= motion_mode ? upd.start_point[31:16] : emitter_x;
    emit.base_y   <= motion_mode ? upd.start_point[15:0] : emitter_y;
    emit.color    <= upd.color;
    emit.size     <= upd.size_st[31:16];
    emit.rotation <= upd.rot_st[31:16];
  end

endmodule

`default_nettype wire

// ----- hdl/rpu_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rpu_out_fifo
// Result queue between the pipeline and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rpu_out_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [rpu_pkg::OUT_DATA_W:0]   wr_data,
  output      logic                           rd_valid,
  input  wire logic                           rd_en,
  output      logic [rpu_pkg::OUT_DATA_W:0]   rd_data
);
  import rpu_pkg::*;

  logic [OUT_DATA_W:0] buffer [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_AW:0]    count;

  assign rd_valid = count != '0;
  assign rd_data  = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buffer[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW + 1)'(wr_en) - (FIFO_AW + 1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/radial_particle_update.sv -----
// ----------------------------------------------------------------------------
// radial_particle_update
// Pool of orbiting particle slots: spawn and advance transactions update one
// slot each and return its position, color, size and rotation.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while s_axis_tready is high and
// returns one result for each, in order, through the slot memory, the trig
// pipeline, the delay registers and the result queue. The slot memory reads,
// updates and writes back a slot per transaction, with forwarding when the
// same slot comes twice in a row. After reset the block clears SLOT_COUNT
// slots, one per cycle, with s_axis_tready low until done. SINE_TABLE_ENTRIES
// must be a power of two. Configuration writes are taken at any time.
`default_nettype none

module radial_particle_update #(
  parameter int SLOT_COUNT         = 64,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // slot, dt, life, start_angle, angle_rate, start_radius, radius_rate,
  // start_color, color_rate, size_pack, rotation_pack
  input  wire logic [rpu_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_slot, pos_x, pos_y, color, size, rotation
  output      logic [rpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // alive
  output      logic        m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rpu_pkg::*;

  localparam int TAB_LOG = $clog2(SINE_TABLE_ENTRIES);
  localparam logic [15:0] PHASE_MASK = 16'(~((32'd1 << (16 - TAB_LOG)) - 32'd1));

  logic [15:0]       emitter_x;
  logic [15:0]       emitter_y;
  logic              motion_mode;
  logic              clearing;
  logic              in_accept;
  logic              out_accept;
  logic [FIFO_AW:0]  occ;
  item_t             item;
  emit_t             p2;
  emit_t             dly [4];
  emit_t             p6;
  logic signed [15:0] sin_q;
  logic signed [15:0] cos_q;
  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic [15:0]       pos_x;
  logic [15:0]       pos_y;
  logic [31:0]       color;
  logic [OUT_DATA_W:0] fifo_wr;
  logic [OUT_DATA_W:0] fifo_rd;

  assign item.cmd           = cmd_t'(s_axis_tuser);
  assign item.slot          = s_axis_tdata[5:0];
  assign item.dt            = s_axis_tdata[21:6];
  assign item.life          = s_axis_tdata[45:22];
  assign item.start_angle   = s_axis_tdata[61:46];
  assign item.angle_rate    = s_axis_tdata[77:62];
  assign item.start_radius  = s_axis_tdata[93:78];
  assign item.radius_rate   = s_axis_tdata[109:94];
  assign item.start_color   = s_axis_tdata[141:110];
  assign item.color_rate    = s_axis_tdata[205:142];
  assign item.size_pack     = s_axis_tdata[237:206];
  assign item.rotation_pack = s_axis_tdata[269:238];

  assign s_axis_tready = !clearing && (occ < (FIFO_AW + 1)'(FIFO_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitter_x   <= '0;
      emitter_y   <= '0;
      motion_mode <= 1'b0;
      occ         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EMITTER_X:   emitter_x   <= cfg_data;
          CFG_EMITTER_Y:   emitter_y   <= cfg_data;
          CFG_MOTION_MODE: motion_mode <= cfg_data[0];
          default: ;
        endcase
      end
      occ <= occ + (FIFO_AW + 1)'(in_accept) - (FIFO_AW + 1)'(out_accept);
    end
  end

  rpu_slot_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slot_mem (
    .clk,
    .rst,
    .accept(in_accept),
    .item,
    .emitter_x,
    .emitter_y,
    .motion_mode,
    .clearing,
    .emit(p2)
  );

  rpu_trig u_trig (
    .clk,
    .phase(p2.angle & PHASE_MASK),
    .sin_q14(sin_q),
    .cos_q14(cos_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        dly[k] <= '0;
      end
      p6 <= '0;
    end else begin
      dly[0] <= p2;
      for (int k = 1; k < 4; k++) begin
        dly[k] <= dly[k-1];
      end
      p6 <= dly[3];
    end
    prod_x <= $signed(dly[3].radius) * cos_q;
    prod_y <= $signed(dly[3].radius) * sin_q;
  end

  always_comb begin
    pos_x = sat16(19'($signed(prod_x[31:14])) + 19'($signed(p6.base_x)));
    pos_y = sat16(19'($signed(prod_y[31:14])) + 19'($signed(p6.base_y)));
    for (int ch = 0; ch < 4; ch++) begin
      color[8*ch +: 8] = color_out(p6.color[16*ch +: 16]);
    end
    if (p6.alive) begin
      fifo_wr = {1'b1, 2'b00, p6.rotation, p6.size, color, pos_y, pos_x, p6.slot};
    end else begin
      fifo_wr = {1'b0, 2'b00, 96'd0, p6.slot};
    end
  end

  rpu_out_fifo u_out_fifo (
    .clk,
    .rst,
    .wr_en(p6.valid),
    .wr_data(fifo_wr),
    .rd_valid(m_axis_tvalid),
    .rd_en(out_accept),
    .rd_data(fifo_rd)
  );

  assign m_axis_tuser = fifo_rd[OUT_DATA_W];
  assign m_axis_tdata = fifo_rd[OUT_DATA_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/rpu_checker.sv -----
// ----------------------------------------------------------------------------
// rpu_checker
// Port-level checks of the radial particle update block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module rpu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [rpu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import rpu_pkg::*;

  // The slot clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during slot clearing");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown after reset");

  // A dead slot reports zeros in every field but the slot index.
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[101:6] == '0)
    else $error("dead slot result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind radial_particle_update rpu_checker u_rpu_checker (.*);

`default_nettype wire
